// ===== hw/rtl/tmpg_pkg.sv =====
// Shared types and constants for the text-mode cell pixel generator.
// Used by every module of the block; it depends on nothing else.
package tmpg_pkg;

  localparam int unsigned AddrWidth  = 16;
  localparam int unsigned AddrCmpW   = (AddrWidth < 16) ? AddrWidth : 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned DotIdxW    = 4;
  localparam int unsigned NumDots    = 9;
  localparam logic [2:0]  LineGfxTop = 3'b110;  // codes 0xC0..0xDF

  typedef enum logic [CfgIdxW-1:0] {
    RegCursorAddr  = 3'd0,
    RegEightDot    = 3'd1,
    RegDoubleWidth = 3'd2,
    RegBlinkEnable = 3'd3,
    RegLineGfx     = 3'd4
  } tmpg_reg_e;

  typedef struct packed {
    logic [15:0] cursor_address;
    logic        eight_dot;
    logic        double_width;
    logic        blink_enable;
    logic        line_graphics;
  } tmpg_cfg_t;

  // One classified cell: dots[i] set picks foreground for pixel i, leftmost first.
  typedef struct packed {
    logic [NumDots-1:0] dots;
    logic [3:0]         fg;
    logic [3:0]         bg;
    logic               nine;
    logic               dbl;
  } tmpg_cell_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tmpg_q_status_t;

endpackage

// ===== hw/rtl/tmpg_front.sv =====
// Front end: resolves cursor, blink and ninth-dot rules for one cell.
// Depends on tmpg_pkg for the configuration and cell types.
module tmpg_front (
  input  tmpg_pkg::tmpg_cfg_t  cfg_i,
  input  logic [7:0]           char_code_i,
  input  logic [7:0]           attribute_i,
  input  logic [7:0]           glyph_row_i,
  input  logic [15:0]          cell_address_i,
  input  logic                 cursor_visible_i,
  input  logic                 blink_phase_i,
  output tmpg_pkg::tmpg_cell_t cell_o
);
  import tmpg_pkg::*;

  logic       cursor_hit;
  logic       blinking;
  logic       ninth_on;
  logic [3:0] fg;
  logic [3:0] bg;

  assign cursor_hit = cursor_visible_i &&
                      (cell_address_i[AddrCmpW-1:0] == cfg_i.cursor_address[AddrCmpW-1:0]);
  assign blinking   = attribute_i[7] && cfg_i.blink_enable;
  assign ninth_on   = cfg_i.line_graphics && (char_code_i[7:5] == LineGfxTop) &&
                      glyph_row_i[0];

  always_comb begin
    if (cursor_hit) begin
      fg = attribute_i[7:4];
      bg = attribute_i[3:0];
    end else if (blinking) begin
      bg = {1'b0, attribute_i[6:4]};
      fg = blink_phase_i ? {1'b0, attribute_i[6:4]} : attribute_i[3:0];
    end else begin
      fg = attribute_i[3:0];
      bg = attribute_i[7:4];
    end
  end

  always_comb begin
    cell_o.fg   = fg;
    cell_o.bg   = bg;
    cell_o.nine = ~cfg_i.eight_dot;
    cell_o.dbl  = cfg_i.double_width;
    for (int i = 0; i < 8; i++) begin
      cell_o.dots[i] = glyph_row_i[7-i];
    end
    cell_o.dots[8] = ninth_on;
  end

endmodule

// ===== hw/rtl/tmpg_queue.sv =====
// Two-entry queue of classified cells between front and back end.
// Depends on tmpg_pkg for the cell and status types.
module tmpg_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_i,
  input  tmpg_pkg::tmpg_cell_t   wdata_i,
  input  logic                   rd_i,
  output tmpg_pkg::tmpg_cell_t   rdata_o,
  output tmpg_pkg::tmpg_q_status_t status_o
);
  import tmpg_pkg::*;

  tmpg_cell_t mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       do_wr, do_rd;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign do_wr   = wr_i && !status_o.full;
  assign do_rd   = rd_i && !status_o.empty;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = do_wr ? ~wptr_q : wptr_q;
    rptr_d  = do_rd ? ~rptr_q : rptr_q;
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/tmpg_back.sv =====
// Back end: serializes a classified cell into one pixel per clock unless stalled.
// Depends on tmpg_pkg for the cell type; owns the output register.
module tmpg_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cell_avail_i,
  input  tmpg_pkg::tmpg_cell_t cell_i,
  output logic                 cell_take_o,
  output logic                 empty,
  input  logic                 pop,
  output logic [3:0]           color_index_o,
  output logic                 last_pixel_o
);
  import tmpg_pkg::*;

  tmpg_cell_t        cur_q;
  logic              cur_valid_q, cur_valid_d;
  logic [DotIdxW-1:0] idx_q, idx_d;
  logic              rep_q, rep_d;
  logic              out_valid_q, out_valid_d;
  logic [3:0]        color_q, color_d;
  logic              last_q, last_d;
  logic              out_ready, emit, last_dot, last_rep, cell_done, load;

  assign out_ready   = !out_valid_q || pop;
  assign emit        = cur_valid_q && out_ready;
  assign last_dot    = (idx_q == (cur_q.nine ? DotIdxW'(NumDots - 1) : DotIdxW'(NumDots - 2)));
  assign last_rep    = !cur_q.dbl || rep_q;
  assign cell_done   = emit && last_dot && last_rep;
  assign load        = cell_avail_i && (!cur_valid_q || cell_done);
  assign cell_take_o = load;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q;
    color_d     = color_q;
    last_d      = last_q;
    if (out_ready) begin
      out_valid_d = emit;
    end
    if (emit) begin
      color_d = cur_q.dots[idx_q] ? cur_q.fg : cur_q.bg;
      last_d  = last_dot && last_rep;
      if (last_rep) begin
        rep_d = 1'b0;
        idx_d = idx_q + DotIdxW'(1);
      end else begin
        rep_d = 1'b1;
      end
    end
    if (cell_done) begin
      cur_valid_d = 1'b0;
    end
    if (load) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
      rep_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      rep_q       <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      rep_q       <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cell_i;
    end
    color_q <= color_d;
    last_q  <= last_d;
  end

  assign empty         = !out_valid_q;
  assign color_index_o = color_q;
  assign last_pixel_o  = last_q;

endmodule

// ===== hw/rtl/text_mode_cell_pixel_generator_core.sv =====
// Top level of the text-mode cell pixel generator: configuration registers,
// front end, cell queue and pixel back end. Depends on tmpg_pkg and all tmpg_* modules.
//
// Usage:
//   Input channel: one beat is one character cell (code, attribute, glyph row
//   byte, cell address, cursor and blink phases). A beat is taken on a rising
//   edge with push high and full low.
//   Result channel: one beat is one pixel colour index plus last_pixel_o, which
//   marks the final pixel of a cell. While empty is low the oldest pixel sits on
//   the ports; it is taken on a rising edge with pop high.
//   A cell gives 8, 9, 16 or 18 pixels (eight_dot, double_width). Pixels leave
//   at one per clock unless pop stalls them; the serializer in the back end sets
//   this rate.
//   On its way out a cell passes from the queue into the back end's cell
//   register, and each of its pixels then into the output register.
//   A two-entry cell queue decouples the sides: cells are taken while pixels of
//   earlier cells are still going out. When pop is held low, hold the pixel,
//   stall the serializer, fill the queue, then raise full.
//   Configuration: write cfg_we_i with cfg_idx_i / cfg_data_i, only while idle.
//   Indexes: 0 cursor address, 1 eight-dot, 2 double width, 3 blink enable,
//   4 line graphics; other indexes are dropped.
//   Reset (rst_ni low, asynchronous) empties the block and clears the configuration.
module text_mode_cell_pixel_generator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tmpg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tmpg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   char_code_i,
  input  logic [7:0]                   attribute_i,
  input  logic [7:0]                   glyph_row_i,
  input  logic [15:0]                  cell_address_i,
  input  logic                         cursor_visible_i,
  input  logic                         blink_phase_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [3:0]                   color_index_o,
  output logic                         last_pixel_o
);
  import tmpg_pkg::*;

  tmpg_cfg_t      cfg_q;
  tmpg_cell_t     front_cell;
  tmpg_cell_t     q_cell;
  tmpg_q_status_t q_status;
  logic           q_take;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCursorAddr:  cfg_q.cursor_address <= cfg_data_i[15:0];
        RegEightDot:    cfg_q.eight_dot      <= cfg_data_i[0];
        RegDoubleWidth: cfg_q.double_width   <= cfg_data_i[0];
        RegBlinkEnable: cfg_q.blink_enable   <= cfg_data_i[0];
        RegLineGfx:     cfg_q.line_graphics  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Classify the incoming cell combinationally; the queue registers it.
  tmpg_front u_front (
    .cfg_i            (cfg_q),
    .char_code_i      (char_code_i),
    .attribute_i      (attribute_i),
    .glyph_row_i      (glyph_row_i),
    .cell_address_i   (cell_address_i),
    .cursor_visible_i (cursor_visible_i),
    .blink_phase_i    (blink_phase_i),
    .cell_o           (front_cell)
  );

  tmpg_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wdata_i  (front_cell),
    .rd_i     (q_take),
    .rdata_o  (q_cell),
    .status_o (q_status)
  );

  assign full = q_status.full;

  // Serialize cells into pixels, one per clock unless pop stalls, into the output register.
  tmpg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cell_avail_i  (!q_status.empty),
    .cell_i        (q_cell),
    .cell_take_o   (q_take),
    .empty         (empty),
    .pop           (pop),
    .color_index_o (color_index_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule
